FILE: sv/nlr_pkg.sv
// ----------------------------------------------------------------------------
// nlr_pkg
// Shared types, constants and table functions of the number literal recognizer.
// ----------------------------------------------------------------------------
`default_nettype none

package nlr_pkg;

	localparam int unsigned OUT_LEN_BITS = 16;
	localparam logic [OUT_LEN_BITS-1:0] OUT_LEN_MAX = 16'hFFFF;

	localparam logic [7:0] LOWER_BIT = 8'h20;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_O      = 8'h6F;
	localparam logic [7:0] CH_X      = 8'h78;

	typedef enum logic [3:0] {
		Q_NONE  = 4'd0,
		Q_BAD   = 4'd1,
		Q_START = 4'd2,
		Q_DOT   = 4'd3,
		Q_ESIGN = 4'd4,
		Q_EXP   = 4'd5,
		Q_INT   = 4'd6,
		Q_EDIG  = 4'd7,
		Q_FRAC  = 4'd8,
		Q_ZERO  = 4'd9,
		Q_PHEX  = 4'd10,
		Q_POCT  = 4'd11,
		Q_PBIN  = 4'd12,
		Q_HEX   = 4'd13,
		Q_OCT   = 4'd14,
		Q_BIN   = 4'd15
	} scan_state_t;

	typedef enum logic [3:0] {
		K_OTH   = 4'd0,
		K_ZERO  = 4'd1,
		K_ONE   = 4'd2,
		K_LOW   = 4'd3,
		K_HIGH  = 4'd4,
		K_HEXL  = 4'd5,
		K_POINT = 4'd6,
		K_EXPL  = 4'd7,
		K_SIGN  = 4'd8,
		K_UNDER = 4'd9
	} char_class_t;

	typedef enum logic [1:0] {
		P_NONE = 2'd0,
		P_BIN  = 2'd1,
		P_OCT  = 2'd2,
		P_HEX  = 2'd3
	} prefix_t;

	typedef enum logic [2:0] {
		V_SCAN   = 3'd0,
		V_ACCEPT = 3'd1,
		V_REJECT = 3'd2,
		V_NODIG  = 3'd3,
		V_IDLE   = 3'd4
	} verdict_t;

	typedef struct packed {
		char_class_t cls;
		prefix_t     pfx;
		logic        begin_tok;
		logic        ended;
	} entry_t;

	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t k;
		k = K_OTH;
		if (c == 8'h5F) k = K_UNDER;
		else if (c == 8'h2E) k = K_POINT;
		else if (c inside {8'h65, 8'h45}) k = K_EXPL;
		else if (c inside {8'h2B, 8'h2D}) k = K_SIGN;
		else if (c == 8'h30) k = K_ZERO;
		else if (c == 8'h31) k = K_ONE;
		else if (c inside {[8'h32:8'h37]}) k = K_LOW;
		else if (c inside {8'h38, 8'h39}) k = K_HIGH;
		else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) k = K_HEXL;
		return k;
	endfunction

	function automatic logic is_digit(input char_class_t k);
		return k inside {K_ZERO, K_ONE, K_LOW, K_HIGH};
	endfunction

	function automatic scan_state_t next_state(input scan_state_t q, input char_class_t k);
		scan_state_t n;
		logic        dig;
		dig = is_digit(k);
		n   = Q_BAD;
		if (k == K_OTH) begin
			n = Q_NONE;
		end else begin
			case (q)
				Q_NONE:  n = Q_NONE;
				Q_BAD:   n = (k inside {K_POINT, K_EXPL, K_SIGN}) ? Q_NONE : Q_BAD;
				Q_START: begin
					if (k == K_ZERO) n = Q_ZERO;
					else if (dig) n = Q_INT;
				end
				Q_DOT:   if (dig) n = Q_FRAC;
				Q_ESIGN: if (dig) n = Q_EDIG;
				Q_EXP: begin
					if (dig) n = Q_EDIG;
					else if (k == K_SIGN) n = Q_ESIGN;
				end
				Q_INT, Q_ZERO: begin
					if (dig || k == K_UNDER) n = Q_INT;
					else if (k == K_POINT) n = Q_DOT;
					else if (k == K_EXPL) n = Q_EXP;
				end
				Q_EDIG:  if (dig || k == K_UNDER) n = Q_EDIG;
				Q_FRAC: begin
					if (dig || k == K_UNDER) n = Q_FRAC;
					else if (k == K_EXPL) n = Q_EXP;
				end
				Q_PHEX:  if (dig || k == K_HEXL) n = Q_HEX;
				Q_POCT:  if (k inside {K_ZERO, K_ONE, K_LOW}) n = Q_OCT;
				Q_PBIN:  if (k inside {K_ZERO, K_ONE}) n = Q_BIN;
				Q_HEX:   if (dig || k inside {K_HEXL, K_EXPL, K_UNDER}) n = Q_HEX;
				Q_OCT:   if (k inside {K_ZERO, K_ONE, K_LOW, K_UNDER}) n = Q_OCT;
				Q_BIN:   if (k inside {K_ZERO, K_ONE, K_UNDER}) n = Q_BIN;
				default: n = Q_NONE;
			endcase
		end
		return n;
	endfunction

endpackage

`default_nettype wire

FILE: sv/nlr_front.sv
// ----------------------------------------------------------------------------
// nlr_front
// Accepts characters, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module nlr_front #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [7:0]    char_code,
	input  wire logic          begin_token,
	input  wire logic          text_ended,
	input  wire logic          push,
	output logic               full,
	output logic               q_valid,
	output nlr_pkg::entry_t    q_head,
	input  wire logic          q_pop
);
	import nlr_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	entry_t             mem [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   fill_q;
	logic               wr_en;
	logic [7:0]         low_char;
	entry_t             wr_entry;

	assign full    = (fill_q == CNT_W'(DEPTH));
	assign q_valid = (fill_q != '0);
	assign wr_en   = push && !full;
	assign q_head  = mem[rd_ptr_q];

	// prefix letters matched with the lower-case bit forced
	assign low_char = char_code | LOWER_BIT;

	always_comb begin
		wr_entry.cls       = classify(char_code);
		wr_entry.begin_tok = begin_token;
		wr_entry.ended     = text_ended;
		if (low_char == CH_B) wr_entry.pfx = P_BIN;
		else if (low_char == CH_O) wr_entry.pfx = P_OCT;
		else if (low_char == CH_X) wr_entry.pfx = P_HEX;
		else wr_entry.pfx = P_NONE;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({wr_en, q_pop})
				2'b10:   fill_q <= fill_q + CNT_W'(1);
				2'b01:   fill_q <= fill_q - CNT_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: sv/nlr_back.sv
// ----------------------------------------------------------------------------
// nlr_back
// Runs the literal scanner over queued beats and registers one result each.
// ----------------------------------------------------------------------------
`default_nettype none

module nlr_back #(
	parameter int unsigned LENGTH_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_valid,
	input  wire nlr_pkg::entry_t               q_head,
	output logic                               q_pop,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [2:0]                         verdict,
	output logic [nlr_pkg::OUT_LEN_BITS-1:0]   token_length
);
	import nlr_pkg::*;

	scan_state_t              state_q;
	logic                     active_q;
	logic [LENGTH_BITS-1:0]   count_q;
	logic                     out_valid_q;
	verdict_t                 verdict_q;
	logic [OUT_LEN_BITS-1:0]  len_q;

	logic                     take;
	scan_state_t              tab_state;
	scan_state_t              state_d;
	logic                     active_d;
	logic [LENGTH_BITS-1:0]   count_d;
	logic [LENGTH_BITS-1:0]   count_inc;
	verdict_t                 res_verdict;
	logic [OUT_LEN_BITS-1:0]  res_len;
	logic [OUT_LEN_BITS-1:0]  close_len;
	verdict_t                 close_verdict;

	assign take         = q_valid && (!out_valid_q || pop);
	assign q_pop        = take;
	assign empty        = !out_valid_q;
	assign verdict      = verdict_q;
	assign token_length = len_q;

	assign count_inc = (&count_q) ? count_q : count_q + LENGTH_BITS'(1);
	assign tab_state = next_state(state_q, q_head.cls);

	generate
		if (LENGTH_BITS > OUT_LEN_BITS) begin : g_len_sat
			assign close_len = (count_q > LENGTH_BITS'(OUT_LEN_MAX)) ? OUT_LEN_MAX
			                 : count_q[OUT_LEN_BITS-1:0];
		end else begin : g_len_ext
			assign close_len = OUT_LEN_BITS'(count_q);
		end
	endgenerate

	assign close_verdict = (state_q >= Q_INT) ? V_ACCEPT : V_REJECT;

	always_comb begin
		state_d     = state_q;
		active_d    = active_q;
		count_d     = count_q;
		res_verdict = V_SCAN;
		res_len     = '0;
		if (q_head.ended) begin
			if (active_q) begin
				res_verdict = close_verdict;
				res_len     = (close_verdict == V_ACCEPT) ? close_len : '0;
				state_d     = Q_NONE;
				active_d    = 1'b0;
				count_d     = '0;
			end else begin
				res_verdict = V_IDLE;
			end
		end else if (q_head.begin_tok) begin
			if (!is_digit(q_head.cls)) begin
				res_verdict = V_NODIG;
				state_d     = Q_NONE;
				active_d    = 1'b0;
				count_d     = '0;
			end else begin
				state_d  = next_state(Q_START, q_head.cls);
				active_d = 1'b1;
				count_d  = LENGTH_BITS'(1);
			end
		end else if (!active_q) begin
			res_verdict = V_IDLE;
		end else if (state_q == Q_ZERO && q_head.pfx != P_NONE) begin
			case (q_head.pfx)
				P_BIN:   state_d = Q_BIN;
				P_OCT:   state_d = Q_OCT;
				default: state_d = Q_HEX;
			endcase
			count_d = count_inc;
		end else if (tab_state == Q_NONE) begin
			res_verdict = close_verdict;
			res_len     = (close_verdict == V_ACCEPT) ? close_len : '0;
			state_d     = Q_NONE;
			active_d    = 1'b0;
			count_d     = '0;
		end else if (tab_state == Q_BAD) begin
			res_verdict = V_REJECT;
			state_d     = Q_NONE;
			active_d    = 1'b0;
			count_d     = '0;
		end else begin
			state_d = tab_state;
			count_d = count_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= Q_NONE;
			active_q    <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				state_q  <= state_d;
				active_q <= active_d;
				count_q  <= count_d;
			end
			if (take) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			verdict_q <= res_verdict;
			len_q     <= res_len;
		end
	end

	// an open candidate always sits in a live scan state
	assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (state_q != Q_NONE && state_q != Q_BAD && count_q != '0))
		else $error("open candidate in dead scan state");

	// idle scanner holds no leftovers
	assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (state_q == Q_NONE && count_q == '0))
		else $error("idle scanner not cleared");

	// length only reported with an accepted token
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && verdict_q != V_ACCEPT) |-> (len_q == '0))
		else $error("length on non-accepted result");

	// a taken beat leaves a result waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid_q)
		else $error("taken beat lost its result");

	// no beat taken while the held result is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |-> !take)
		else $error("result overwritten while stalled");

endmodule

`default_nettype wire

FILE: sv/number_literal_recognizer_top.sv
// ----------------------------------------------------------------------------
// number_literal_recognizer_top
// Character-serial recogniser for decimal, fractional, exponent and prefixed
// number literals.
// ----------------------------------------------------------------------------
// Input side is a queue: drive char_code, begin_token and text_ended with
// push; a beat is taken at a clock edge where push is high and full is low.
// Output side is a queue: while empty is low the oldest result is on verdict
// and token_length; it is taken at a clock edge where pop is high and empty
// is low.
// Every input beat gives exactly one result beat, in order.
// A beat taken at the input is written into the queue memory, then into the
// result register by the scanner when the path is free. Throughput: one beat
// per cycle while results are taken, set by the back-end scanner update.
// A QUEUE_DEPTH-entry queue sits between the classifier and the scanner, so
// the input keeps taking beats while a result waits; when pop stays low the
// queue fills and full rises.
// Reset empties the queue and the result register and leaves the scanner
// idle with zero length.
// ----------------------------------------------------------------------------
`default_nettype none

module number_literal_recognizer_top #(
	parameter int unsigned LENGTH_BITS = 16,
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [7:0]                    char_code,
	input  wire logic                          begin_token,
	input  wire logic                          text_ended,
	input  wire logic                          push,
	output logic                               full,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [2:0]                         verdict,
	output logic [nlr_pkg::OUT_LEN_BITS-1:0]   token_length
);
	import nlr_pkg::*;

	logic   q_valid;
	logic   q_pop;
	entry_t q_head;

	nlr_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_code   (char_code),
		.begin_token (begin_token),
		.text_ended  (text_ended),
		.push        (push),
		.full        (full),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_pop       (q_pop)
	);

	nlr_back #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.empty        (empty),
		.pop          (pop),
		.verdict      (verdict),
		.token_length (token_length)
	);

endmodule

`default_nettype wire
